>>> design/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// Shared constants, register indexes and the byte substitution function.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int RoundKeyWordsDefault = 60;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 64;

   localparam logic [CsrIndexWidth-1:0] CSR_KEY_SIZE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD_3 = 3'd4;

   typedef logic [7:0] byte_type;
   typedef logic [31:0] word_type;
   typedef logic [127:0] block_type;

   function automatic byte_type sbox(input byte_type b);
      byte_type r;
      case (b)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
      endcase
      return r;
   endfunction

   function automatic word_type sbox_word(input word_type w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic byte_type mul2(input byte_type b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

>>> design/aes_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
   parameter int Width = 32,
   parameter int Depth = 60
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/aes_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round unit
// One full cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// ----------------------------------------------------------------------------
module aes_round (
   input  aes_pkg::block_type state_in,
   input  aes_pkg::block_type round_key,
   input  logic               last_round,
   output aes_pkg::block_type state_out
);
   aes_pkg::byte_type st [16];
   aes_pkg::byte_type sh [16];
   aes_pkg::byte_type mx [16];
   aes_pkg::block_type packed_mx;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         st[i] = state_in[127-8*i -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sh[c*4+r] = aes_pkg::sbox(st[((c+r)%4)*4+r]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         mx[c*4]   = aes_pkg::mul2(sh[c*4]) ^ aes_pkg::mul2(sh[c*4+1]) ^ sh[c*4+1]
                   ^ sh[c*4+2] ^ sh[c*4+3];
         mx[c*4+1] = sh[c*4] ^ aes_pkg::mul2(sh[c*4+1]) ^ aes_pkg::mul2(sh[c*4+2])
                   ^ sh[c*4+2] ^ sh[c*4+3];
         mx[c*4+2] = sh[c*4] ^ sh[c*4+1] ^ aes_pkg::mul2(sh[c*4+2])
                   ^ aes_pkg::mul2(sh[c*4+3]) ^ sh[c*4+3];
         mx[c*4+3] = aes_pkg::mul2(sh[c*4]) ^ sh[c*4] ^ sh[c*4+1] ^ sh[c*4+2]
                   ^ aes_pkg::mul2(sh[c*4+3]);
      end
      for (int i = 0; i < 16; i++) begin
         packed_mx[127-8*i -: 8] = last_round ? sh[i] : mx[i];
      end
      state_out = packed_mx ^ round_key;
   end
endmodule

>>> design/aes_block_encrypt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block encrypt unit
// AES-128/256 forward cipher with an on-chip key schedule store.
// ----------------------------------------------------------------------------
// Round keys are read one word per cycle, four per round, and each round is
// applied when its fourth word arrives. A new request is taken only in idle,
// after the last result has left the done state; a result that is not taken
// holds the next one in its done state. The first request after reset or a
// key register write first expands the key, one schedule word per cycle.
// Reset is synchronous and active high; it clears control state and keys.
module aes_block_encrypt_unit #(
   parameter int RoundKeyWords = aes_pkg::RoundKeyWordsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [63:0]                       req_plain_high,
   input  logic [63:0]                       req_plain_low,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [63:0]                       rsp_cipher_high,
   output logic [63:0]                       rsp_cipher_low,
   input  logic                              csr_write_enable,
   input  logic [aes_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [aes_pkg::CsrDataWidth-1:0]  csr_write_data
);
   localparam int AddrWidth = $clog2(RoundKeyWords);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXPAND = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;

   logic [2:0] state_ff, state_in;
   logic       key_size_ff;
   logic [63:0] key_ff [4];
   logic       sched_valid_ff;
   logic       rsp_valid_ff;
   logic       cfg_hit;
   logic [5:0] widx_ff, widx_in;        // expansion word index
   logic [5:0] ridx_ff, ridx_in;        // next round-key word to read
   logic [1:0] col_ff, col_in;          // column of the arriving key word
   logic       fetch_ff, fetch_in;      // read data valid this cycle
   logic [3:0] round_ff, round_in;
   aes_pkg::word_type win_ff [8];       // last eight schedule words
   aes_pkg::word_type rk_ff [4];
   aes_pkg::block_type block_ff, block_in;
   aes_pkg::block_type round_out;
   aes_pkg::block_type rk_block;
   aes_pkg::word_type new_word, tword, key_word, sched_word, rk_word;
   aes_pkg::byte_type rcon_ff;
   logic [2:0] kpos_ff;                 // widx mod nk
   logic [3:0] rounds;
   logic [5:0] total;
   logic [5:0] nk_words;
   logic       ram_we;
   aes_pkg::word_type rd_data;
   logic [63:0] out_hi_ff, out_lo_ff;

   assign rounds = key_size_ff ? 4'd14 : 4'd10;
   assign total = key_size_ff ? 6'd60 : 6'd44;
   assign nk_words = key_size_ff ? 6'd8 : 6'd4;

   always_comb begin
      tword = win_ff[7];
      if (kpos_ff == 3'd0) begin
         tword = aes_pkg::sbox_word({win_ff[7][23:0], win_ff[7][31:24]})
               ^ {rcon_ff, 24'h0};
      end else if (key_size_ff && kpos_ff == 3'd4) begin
         tword = aes_pkg::sbox_word(win_ff[7]);
      end
      new_word = (key_size_ff ? win_ff[0] : win_ff[4]) ^ tword;
      key_word = widx_ff[0] ? key_ff[widx_ff[2:1]][31:0] : key_ff[widx_ff[2:1]][63:32];
      // The first nk schedule words are the key itself.
      sched_word = (widx_ff < nk_words) ? key_word : new_word;
   end

   assign ram_we = (state_ff == ST_EXPAND) && (widx_ff < 6'(RoundKeyWords));

   aes_ram #(.Width(32), .Depth(RoundKeyWords)) u_rk_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (widx_ff[AddrWidth-1:0]),
      .wr_data (sched_word),
      .rd_addr (ridx_ff[AddrWidth-1:0]),
      .rd_data (rd_data)
   );

   // Words beyond a small store read as zero.
   assign rk_word = (ridx_ff - 6'd1 < 6'(RoundKeyWords)) ? rd_data : 32'h0;
   assign rk_block = {rk_ff[0], rk_ff[1], rk_ff[2], rk_word};

   aes_round u_round (
      .state_in   (block_ff),
      .round_key  (rk_block),
      .last_round (round_ff == rounds),
      .state_out  (round_out)
   );

   always_comb begin
      state_in = state_ff;
      widx_in = widx_ff;
      ridx_in = ridx_ff;
      col_in = col_ff;
      fetch_in = 1'b0;
      round_in = round_ff;
      block_in = block_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               block_in = {req_plain_high, req_plain_low};
               ridx_in = 6'd0;
               col_in = 2'd0;
               round_in = 4'd0;
               widx_in = 6'd0;
               state_in = sched_valid_ff ? ST_LOAD : ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            widx_in = widx_ff + 6'd1;
            if (widx_ff == total - 6'd1) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Issue one read per cycle; the key word arrives through the registered RAM read.
            if (ridx_ff != total) begin
               fetch_in = 1'b1;
               ridx_in = ridx_ff + 6'd1;
            end
            if (fetch_ff) begin
               col_in = col_ff + 2'd1;
               if (col_ff == 2'd3) begin
                  round_in = round_ff + 4'd1;
                  if (round_ff == 4'd0) begin
                     block_in = block_ff ^ rk_block;
                  end else begin
                     block_in = round_out;
                  end
                  if (round_ff == rounds) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign cfg_hit = csr_write_enable && (csr_index <= aes_pkg::CSR_KEY_WORD_3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sched_valid_ff <= 1'b0;
         key_size_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= 64'h0;
         end
         rsp_valid_ff <= 1'b0;
         fetch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fetch_ff <= fetch_in;
         if (cfg_hit) begin
            sched_valid_ff <= 1'b0;
            case (csr_index)
               aes_pkg::CSR_KEY_SIZE: key_size_ff <= csr_write_data[0];
               aes_pkg::CSR_KEY_WORD_0: key_ff[0] <= csr_write_data;
               aes_pkg::CSR_KEY_WORD_1: key_ff[1] <= csr_write_data;
               aes_pkg::CSR_KEY_WORD_2: key_ff[2] <= csr_write_data;
               default: key_ff[3] <= csr_write_data;
            endcase
         end else if (state_ff == ST_EXPAND && state_in == ST_LOAD) begin
            sched_valid_ff <= 1'b1;
         end
         if (state_ff == ST_DONE && state_in == ST_IDLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      widx_ff <= widx_in;
      ridx_ff <= ridx_in;
      col_ff <= col_in;
      round_ff <= round_in;
      block_ff <= block_in;
      if (fetch_ff) begin
         rk_ff[col_ff] <= rk_word;
      end
      if (state_ff == ST_DONE && state_in == ST_IDLE) begin
         out_hi_ff <= block_ff[127:64];
         out_lo_ff <= block_ff[63:0];
      end
      // Schedule window: every expansion cycle shifts in the current schedule word.
      if (state_ff == ST_IDLE) begin
         kpos_ff <= 3'd0;
         rcon_ff <= 8'h01;
      end else if (state_ff == ST_EXPAND) begin
         for (int i = 0; i < 7; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[7] <= sched_word;
         if (widx_ff >= nk_words) begin
            kpos_ff <= (kpos_ff == (key_size_ff ? 3'd7 : 3'd3)) ? 3'd0 : kpos_ff + 3'd1;
            if (kpos_ff == 3'd0) begin
               rcon_ff <= aes_pkg::mul2(rcon_ff);
            end
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_cipher_high = out_hi_ff;
   assign rsp_cipher_low = out_lo_ff;

   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_expand_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXPAND && state_in == ST_LOAD && !cfg_hit) |=> sched_valid_ff)
      else $error("schedule not marked valid");
   a_rounds_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (round_ff <= rounds))
      else $error("round count overran");
endmodule
